// ===== sv/lzsd_pkg.sv =====
// ----------------------------------------------------------------------------
// lzsd_pkg: shared definitions for the lzss stream decoder
// field widths, result status codes, register map and reset values
// ----------------------------------------------------------------------------
package lzsd_pkg;

    localparam int unsigned HISTORY_DEPTH_DEF = 4096;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 24;
    localparam int unsigned OFS_W   = 13;   // offset field plus one
    localparam int unsigned LEN_W   = 5;    // length field plus three

    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;

    // register map (register index is paddr[2])
    localparam logic REG_OUT_LIMIT = 1'b0;

    localparam logic [COUNT_W-1:0] OUT_LIMIT_RESET = 24'd65535;

    localparam logic [3:0] FLAG_GROUP = 4'd8;
    localparam logic [4:0] MIN_MATCH  = 5'd3;

    typedef enum logic [1:0] {
        STATUS_DATA     = 2'd0,
        STATUS_OFFSET   = 2'd1,
        STATUS_OVERFLOW = 2'd2,
        STATUS_TRUNC    = 2'd3
    } status_t;

endpackage

// ===== sv/lzss_stream_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// lzss_stream_decoder_unit: lzss decoder, 12-bit offset and 4-bit length
//
// usage
//   s_axis carries compressed bytes (tdata = in_byte, tlast = last_in).
//   a flag byte governs the next eight items, lsb first: a clear bit is a
//   literal, a set bit a two-byte little-endian token (low nibble length-3,
//   upper 12 bits offset-1) that copies a run from the 4096-byte history.
//   m_axis carries one beat per decoded byte or error report:
//   tdata = {produced, out_byte}, tuser = status, tlast = last beat caused
//   by one input beat. an error beat is sent once, then the block ignores all
//   input until reset. decoding stops silently at out_limit; a zero limit or
//   a token that would pass it is an overflow. the apb port holds out_limit at
//   byte address 0 (reset 65535); write it only while the decoder is idle.
// timing
//   s_axis_tready is high only while the sequencer waits for a beat.
//   flag byte or token low byte: ST_IDLE, ST_DECIDE; literal: also ST_LIT;
//   token high byte: ST_OFS and ST_LEN follow, then ST_COPY_RD and
//   ST_COPY_WR for each copied byte, since the history read is registered.
//   a stalled receiver holds the sequencer at the next result; the output
//   register keeps its beat until taken. reset clears all control state;
//   the history memory is not cleared (offsets are checked against the
//   count of decoded bytes, so no unwritten entry is ever read).
// ----------------------------------------------------------------------------
module lzss_stream_decoder_unit
    import lzsd_pkg::*;
#(
    parameter int unsigned HISTORY_DEPTH = HISTORY_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // compressed input
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [BYTE_W-1:0]    s_axis_tdata,     // [7:0] in_byte
    input  logic                 s_axis_tlast,     // last_in
    // decoded output
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [31:0]          m_axis_tdata,     // [7:0] out_byte, [31:8] produced
    output logic [1:0]           m_axis_tuser,     // [1:0] status
    output logic                 m_axis_tlast,     // run_end
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    localparam int unsigned HIST_AW = $clog2(HISTORY_DEPTH);

    typedef enum logic [1:0] {
        PH_FLAG  = 2'd0,
        PH_ITEM  = 2'd1,
        PH_TOKEN = 2'd2
    } phase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_OFS,
        ST_LEN,
        ST_LIT,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_ERR
    } state_t;

    // sequencer and decoder state
    state_t               state_reg,      state_next;
    logic [COUNT_W-1:0]   out_limit_reg,  out_limit_next;
    logic [BYTE_W-1:0]    flag_bits_reg,  flag_bits_next;
    logic [3:0]           flags_left_reg, flags_left_next;
    phase_t               phase_reg,      phase_next;
    logic [BYTE_W-1:0]    token_low_reg,  token_low_next;
    logic [COUNT_W-1:0]   out_count_reg,  out_count_next;
    logic                 halted_reg,     halted_next;
    logic [BYTE_W-1:0]    byte_reg,       byte_next;
    logic                 last_reg,       last_next;
    logic [HIST_AW-1:0]   src_reg,        src_next;
    logic [LEN_W-1:0]     copy_left_reg,  copy_left_next;
    status_t              err_status_reg, err_status_next;

    // output register
    logic                 m_valid_reg,    m_valid_next;
    logic [BYTE_W-1:0]    m_byte_reg,     m_byte_next;
    status_t              m_status_reg,   m_status_next;
    logic                 m_last_reg,     m_last_next;
    logic [COUNT_W-1:0]   m_prod_reg,     m_prod_next;

    // history memory
    logic [BYTE_W-1:0]    hist_mem [HISTORY_DEPTH];
    logic [BYTE_W-1:0]    hist_rd_reg;
    logic                 hist_we;
    logic [BYTE_W-1:0]    hist_wdata;

    // shared helpers
    logic                 out_free;
    logic                 cfg_write;
    logic [COUNT_W-1:0]   count_plus1;
    logic [3:0]           flags_left_dec;
    logic                 tail_trunc;
    logic [15:0]          token_word;
    logic [OFS_W-1:0]     offset;
    logic [COUNT_W-1:0]   limit_room;

    assign out_free       = !m_valid_reg || m_axis_tready;
    assign cfg_write      = psel && penable && pwrite && pready && (paddr[2] == REG_OUT_LIMIT);
    assign count_plus1    = out_count_reg + 24'd1;
    assign flags_left_dec = (flags_left_reg == 4'd0) ? 4'd0 : flags_left_reg - 4'd1;
    // a truncated-token report follows the byte about to be emitted
    assign tail_trunc     = last_reg && (count_plus1 < out_limit_reg)
                            && (flags_left_dec != 4'd0) && flag_bits_reg[1];
    assign token_word     = {byte_reg, token_low_reg};
    assign offset         = {1'b0, token_word[15:4]} + 13'd1;
    assign limit_room     = out_limit_reg - out_count_reg;

    assign pready        = 1'b1;
    assign prdata        = (paddr[2] == REG_OUT_LIMIT) ? {8'd0, out_limit_reg} : '0;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {m_prod_reg, m_byte_reg};
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tlast  = m_last_reg;

    always_comb
    begin
        state_next      = state_reg;
        out_limit_next  = out_limit_reg;
        flag_bits_next  = flag_bits_reg;
        flags_left_next = flags_left_reg;
        phase_next      = phase_reg;
        token_low_next  = token_low_reg;
        out_count_next  = out_count_reg;
        halted_next     = halted_reg;
        byte_next       = byte_reg;
        last_next       = last_reg;
        src_next        = src_reg;
        copy_left_next  = copy_left_reg;
        err_status_next = err_status_reg;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        m_byte_next     = m_byte_reg;
        m_status_next   = m_status_reg;
        m_last_next     = m_last_reg;
        m_prod_next     = m_prod_reg;
        hist_we         = 1'b0;
        hist_wdata      = byte_reg;

        if (cfg_write)
        begin
            out_limit_next = pwdata[COUNT_W-1:0];
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    byte_next  = s_axis_tdata;
                    last_next  = s_axis_tlast;
                    state_next = ST_DECIDE;
                end
            end

            ST_DECIDE:
            begin
                if (halted_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_limit_reg == '0 && out_count_reg == '0)
                begin
                    err_status_next = STATUS_OVERFLOW;
                    state_next      = ST_ERR;
                end
                else if (out_count_reg >= out_limit_reg)
                begin
                    halted_next = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    case (phase_reg)
                        PH_ITEM:
                        begin
                            if (!flag_bits_reg[0])
                            begin
                                state_next = ST_LIT;
                            end
                            else
                            begin
                                token_low_next = byte_reg;
                                phase_next     = PH_TOKEN;
                                if (last_reg)
                                begin
                                    err_status_next = STATUS_TRUNC;
                                    state_next      = ST_ERR;
                                end
                                else
                                begin
                                    state_next = ST_IDLE;
                                end
                            end
                        end
                        PH_TOKEN:
                        begin
                            state_next = ST_OFS;
                        end
                        default:
                        begin
                            // flag byte opens a group of eight items
                            flag_bits_next  = byte_reg;
                            flags_left_next = FLAG_GROUP;
                            phase_next      = PH_ITEM;
                            state_next      = ST_IDLE;
                            if (last_reg)
                            begin
                                if (byte_reg[0])
                                begin
                                    err_status_next = STATUS_TRUNC;
                                    state_next      = ST_ERR;
                                end
                                else
                                begin
                                    halted_next = 1'b1;
                                end
                            end
                        end
                    endcase
                end
            end

            ST_OFS:
            begin
                if ({11'd0, offset} > out_count_reg)
                begin
                    err_status_next = STATUS_OFFSET;
                    state_next      = ST_ERR;
                end
                else
                begin
                    src_next       = out_count_reg[HIST_AW-1:0] - offset[HIST_AW-1:0];
                    copy_left_next = {1'b0, token_word[3:0]} + MIN_MATCH;
                    state_next     = ST_LEN;
                end
            end

            ST_LEN:
            begin
                if (limit_room < {19'd0, copy_left_reg})
                begin
                    err_status_next = STATUS_OVERFLOW;
                    state_next      = ST_ERR;
                end
                else
                begin
                    state_next = ST_COPY_RD;
                end
            end

            ST_COPY_RD:
            begin
                state_next = ST_COPY_WR;
            end

            ST_LIT, ST_COPY_WR:
            begin
                if (out_free)
                begin
                    hist_we        = 1'b1;
                    hist_wdata     = (state_reg == ST_LIT) ? byte_reg : hist_rd_reg;
                    m_valid_next   = 1'b1;
                    m_byte_next    = hist_wdata;
                    m_status_next  = STATUS_DATA;
                    m_prod_next    = count_plus1;
                    out_count_next = count_plus1;
                    src_next       = src_reg + 1'b1;
                    copy_left_next = copy_left_reg - 5'd1;
                    if (state_reg == ST_COPY_WR && copy_left_reg != 5'd1)
                    begin
                        m_last_next = 1'b0;
                        state_next  = ST_COPY_RD;
                    end
                    else
                    begin
                        // item done: step to the next flag, then end checks
                        m_last_next     = !tail_trunc;
                        flag_bits_next  = {1'b0, flag_bits_reg[BYTE_W-1:1]};
                        flags_left_next = flags_left_dec;
                        phase_next      = (flags_left_dec == 4'd0) ? PH_FLAG : PH_ITEM;
                        if (count_plus1 >= out_limit_reg || last_reg)
                        begin
                            halted_next = 1'b1;
                        end
                        if (tail_trunc)
                        begin
                            err_status_next = STATUS_TRUNC;
                            state_next      = ST_ERR;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end

            ST_ERR:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_byte_next   = '0;
                    m_status_next = err_status_reg;
                    m_last_next   = 1'b1;
                    m_prod_next   = out_count_reg;
                    halted_next   = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_limit_reg  <= OUT_LIMIT_RESET;
            flag_bits_reg  <= '0;
            flags_left_reg <= '0;
            phase_reg      <= PH_FLAG;
            token_low_reg  <= '0;
            out_count_reg  <= '0;
            halted_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            out_limit_reg  <= out_limit_next;
            flag_bits_reg  <= flag_bits_next;
            flags_left_reg <= flags_left_next;
            phase_reg      <= phase_next;
            token_low_reg  <= token_low_next;
            out_count_reg  <= out_count_next;
            halted_reg     <= halted_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        byte_reg       <= byte_next;
        last_reg       <= last_next;
        src_reg        <= src_next;
        copy_left_reg  <= copy_left_next;
        err_status_reg <= err_status_next;
        m_byte_reg     <= m_byte_next;
        m_status_reg   <= m_status_next;
        m_last_reg     <= m_last_next;
        m_prod_reg     <= m_prod_next;
    end

    // history window: write at the output count, registered read at the copy source
    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[out_count_reg[HIST_AW-1:0]] <= hist_wdata;
        end
        hist_rd_reg <= hist_mem[src_reg];
    end

endmodule
